// ===== rtl/rbi_pkg.sv =====
// rbi_pkg: shared types, opcodes and fixed-point constants for the integrator
// no dependencies
package rbi_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_BITS = 16;
  localparam int NUM_REGS = 7;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_GRAVITY = 2'd0;
  localparam logic [1:0] OP_FORCE   = 2'd1;
  localparam logic [1:0] OP_IMPULSE = 2'd2;
  localparam logic [1:0] OP_STEP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IS_BOX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HY      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HZ      = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [15:0]        dt;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        mass;
    logic               grav_en;
    logic signed [31:0] grav;
    logic               is_box;
    logic [31:0]        hx;
    logic [31:0]        hy;
    logic [31:0]        hz;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== rtl/rigid_body_integrator.sv =====
// rigid_body_integrator: one rigid body, semi-implicit euler, signed fixed point
// depends on rbi_pkg, rbi_front, rbi_back, rbi_divider
//
// usage: commands enter on in_valid/in_stall (opcode, vector, time step);
// every accepted command returns one result transfer on out_valid/out_stall
// carrying position, velocity, orientation and spin after the command.
// configuration registers are written on cfg_valid/cfg_ready; the user must
// write them only while idle, as the block has no check for it. cfg_ready is
// always high, indexes beyond the list are ignored. gravity, force and impulse
// go from decode straight to output; a step runs each linear axis and, for a
// box, then each angular axis after its inertia is computed, through the
// shared one-bit-per-cycle 64-step divider, skipped for zero mass or inertia.
// commands run one at a time; the next one starts the cycle after a result
// transfer. a two-entry command queue lets the input side keep moving while a
// result waits; when out_stall is high the result holds and the sequencer waits.
// reset clears the body state to zero, the registers to their defaults and
// empties the queue.
module rigid_body_integrator import rbi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic signed [31:0]   in_vec_x,
  input  logic signed [31:0]   in_vec_y,
  input  logic signed [31:0]   in_vec_z,
  input  logic [15:0]          in_time_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  output logic signed [31:0]   out_vel_x,
  output logic signed [31:0]   out_vel_y,
  output logic signed [31:0]   out_vel_z,
  output logic signed [31:0]   out_orient_x,
  output logic signed [31:0]   out_orient_y,
  output logic signed [31:0]   out_orient_z,
  output logic signed [31:0]   out_spin_x,
  output logic signed [31:0]   out_spin_y,
  output logic signed [31:0]   out_spin_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  cfg_t cfg_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic signed [31:0] s_pos [3], s_vel [3], s_ori [3], s_spin [3];

  assign cfg_ready = 1'b1;
  assign in_cmd = '{opcode: in_opcode, vx: in_vec_x, vy: in_vec_y, vz: in_vec_z,
                    dt: in_time_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mass: 32'h10000, grav_en: 1'b1, grav: -32'sd642908, is_box: 1'b0,
                 hx: 32'h10000, hy: 32'h10000, hz: 32'h10000};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MASS:    cfg_r.mass <= cfg_data;
        REG_GRAV_EN: cfg_r.grav_en <= cfg_data[0];
        REG_GRAV:    cfg_r.grav <= cfg_data;
        REG_IS_BOX:  cfg_r.is_box <= cfg_data[0];
        REG_HX:      cfg_r.hx <= cfg_data;
        REG_HY:      cfg_r.hy <= cfg_data;
        REG_HZ:      cfg_r.hz <= cfg_data;
        default: ;
      endcase
    end
  end

  rbi_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  rbi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .st_pos(s_pos), .st_vel(s_vel), .st_ori(s_ori), .st_spin(s_spin)
  );

  assign out_pos_x = s_pos[0];
  assign out_pos_y = s_pos[1];
  assign out_pos_z = s_pos[2];
  assign out_vel_x = s_vel[0];
  assign out_vel_y = s_vel[1];
  assign out_vel_z = s_vel[2];
  assign out_orient_x = s_ori[0];
  assign out_orient_y = s_ori[1];
  assign out_orient_z = s_ori[2];
  assign out_spin_x = s_spin[0];
  assign out_spin_y = s_spin[1];
  assign out_spin_z = s_spin[2];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_vel_x))
    else $error("result changed under stall");
  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_pop)
    else $error("command started while result pending");
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
endmodule

// ===== rtl/rbi_front.sv =====
// rbi_front: input acceptance and command queue
// depends on rbi_pkg
module rbi_front import rbi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cmd_t        in_cmd,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  cmd_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic push;

  assign in_stall = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

// ===== rtl/rbi_divider.sv =====
// rbi_divider: restoring divider, signed 64-bit numerator by unsigned 64-bit divisor
// depends on rbi_pkg; one quotient bit per cycle
module rbi_divider import rbi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [63:0]        den,
  output logic               done,
  output logic signed [31:0] quo
);
  logic [63:0] q_r, rem_r, d_r;
  logic neg_r, busy_r, done_r;
  logic [6:0] cnt_r;
  logic [64:0] trial;
  logic [63:0] qs;

  assign trial = {rem_r, q_r[63]} - {1'b0, d_r};
  assign done = done_r;
  assign qs = neg_r ? -q_r : q_r;
  always_comb begin
    if (!neg_r && q_r > 64'd2147483647) quo = 32'sh7fffffff;
    else if (neg_r && q_r > 64'd2147483648) quo = 32'sh80000000;
    else quo = qs[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd64;
        neg_r <= num[63];
        q_r <= num[63] ? -num : num;
        rem_r <= '0;
        d_r <= den;
      end else if (busy_r) begin
        if (!trial[64]) rem_r <= trial[63:0];
        else rem_r <= {rem_r[62:0], q_r[63]};
        q_r <= {q_r[62:0], ~trial[64]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/rbi_back.sv =====
// rbi_back: sequencer that executes queued commands on the body state
// depends on rbi_pkg and rbi_divider
module rbi_back import rbi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] st_pos [3],
  output logic signed [31:0] st_vel [3],
  output logic signed [31:0] st_ori [3],
  output logic signed [31:0] st_spin [3]
);
  localparam logic signed [33:0] DAMP =
    34'(((98 * (64'd1 << FRAC_BITS)) + 50) / 100);
  localparam logic signed [33:0] EPS =
    34'(((64'd1 << FRAC_BITS) + 500) / 1000);

  localparam logic [3:0] S_IDLE = 4'd0, S_DECODE = 4'd1, S_INER = 4'd2,
    S_INER2 = 4'd3, S_DIV = 4'd4, S_DIVW = 4'd5, S_ACC = 4'd6, S_VADD = 4'd7,
    S_DAMP = 4'd8, S_POS = 4'd9, S_OUT = 4'd10, S_FIVE = 4'd11;
  localparam logic [2:0] F_LAST = 3'd6;

  logic [3:0] st_r, st_nxt;
  logic [1:0] ax_r;
  logic       ang_r;
  logic signed [31:0] pos_r [3], vel_r [3], ori_r [3], spin_r [3], frc_r [3];
  logic [63:0] sq_r, inr_r;
  logic [63:0] dn_r, dq_r;
  logic [5:0]  dr_r;
  logic [2:0]  fk_r;
  logic signed [31:0] acc_r;
  logic signed [65:0] prod_r;
  cmd_t cmd_r;
  logic out_valid_r;

  logic div_start, div_done;
  logic signed [63:0] div_num;
  logic [63:0] div_den;
  logic signed [31:0] div_q;

  rbi_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic [31:0] ha, hb;
  logic signed [31:0] vsel, cur;
  always_comb begin
    case (ax_r)
      2'd0: begin ha = cfg.hy; hb = cfg.hz; vsel = cmd_r.vx; end
      2'd1: begin ha = cfg.hx; hb = cfg.hz; vsel = cmd_r.vy; end
      default: begin ha = cfg.hx; hb = cfg.hy; vsel = cmd_r.vz; end
    endcase
    cur = ang_r ? spin_r[ax_r] : vel_r[ax_r];
  end

  logic [63:0] sqa, sqb;
  logic [64:0] sqs;
  assign sqa = (64'(ha) * 64'(ha)) >> (FRAC_BITS - 2);
  assign sqb = (64'(hb) * 64'(hb)) >> (FRAC_BITS - 2);
  assign sqs = 65'(sqa) + 65'(sqb);

  logic [63:0] ma, mb, hi, lo, qv;
  logic [64:0] qsum;
  always_comb begin
    ma = 64'(cfg.mass) * 64'(sq_r[63:32]);
    mb = 64'(cfg.mass) * 64'(sq_r[31:0]);
    lo = mb >> FRAC_BITS;
    if (ma > (64'hffffffffffffffff >> (32 - FRAC_BITS))) hi = '1;
    else hi = ma << (32 - FRAC_BITS);
    qsum = 65'(hi) + 65'(lo);
    qv = qsum[64] ? '1 : qsum[63:0];
  end

  // divide by five: shift-add estimate, then a small remainder correction
  logic [9:0]  f13;
  logic [3:0]  fc;
  logic [63:0] fq;
  logic [2:0]  fr;
  assign f13 = 10'(dr_r) * 10'd13;
  assign fc = 4'(f13 >> 6);
  assign fq = dq_r + 64'(fc);
  assign fr = 3'(dr_r - 6'(fc) * 6'd5);

  logic zero_den;
  assign zero_den = (div_den == '0) || div_den[63];
  assign div_num = (ang_r ? 64'(vsel) : 64'(frc_r[ax_r])) <<< FRAC_BITS;
  assign div_den = ang_r ? inr_r : 64'(cfg.mass);
  assign div_start = (st_r == S_DIV) && !zero_den;

  logic signed [31:0] mres;
  assign mres = sat32(prod_r >>> DT_BITS);
  logic signed [31:0] dres;
  assign dres = sat32(prod_r >>> FRAC_BITS);

  assign q_pop = (st_r == S_IDLE) && q_valid && !out_valid_r;
  assign out_valid = out_valid_r;
  assign st_pos = pos_r;
  assign st_vel = vel_r;
  assign st_ori = ori_r;
  assign st_spin = spin_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:   if (q_pop) st_nxt = S_DECODE;
      S_DECODE: st_nxt = (cmd_r.opcode == OP_STEP) ? S_DIV : S_OUT;
      S_INER:   st_nxt = S_INER2;
      S_INER2:  st_nxt = S_FIVE;
      S_FIVE:   if (fk_r == F_LAST) st_nxt = S_DIV;
      S_DIV:    st_nxt = zero_den ? S_ACC : S_DIVW;
      S_DIVW:   if (div_done) st_nxt = S_ACC;
      S_ACC:    st_nxt = S_VADD;
      S_VADD:   st_nxt = S_DAMP;
      S_DAMP:   st_nxt = S_POS;
      S_POS: begin
        if (ax_r == 2'd2) st_nxt = (!ang_r && cfg.is_box) ? S_INER : S_OUT;
        else st_nxt = ang_r ? S_INER : S_DIV;
      end
      S_OUT:    st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
      ax_r <= '0;
      ang_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0; vel_r[i] <= '0; ori_r[i] <= '0;
        spin_r[i] <= '0; frc_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_pop) begin
          cmd_r <= q_cmd;
          ax_r <= '0;
          ang_r <= 1'b0;
        end
        S_DECODE: begin
          case (cmd_r.opcode)
            OP_GRAVITY: if (cfg.mass != '0 && cfg.grav_en) begin
              frc_r[0] <= '0;
              frc_r[2] <= '0;
              frc_r[1] <= sat32(($signed({1'b0, cfg.mass}) * 66'(cfg.grav))
                >>> FRAC_BITS);
            end
            OP_FORCE: begin
              frc_r[0] <= sat32(66'(frc_r[0]) + 66'(cmd_r.vx));
              frc_r[1] <= sat32(66'(frc_r[1]) + 66'(cmd_r.vy));
              frc_r[2] <= sat32(66'(frc_r[2]) + 66'(cmd_r.vz));
            end
            OP_IMPULSE: begin
              vel_r[0] <= sat32(66'(vel_r[0]) + 66'(cmd_r.vx));
              vel_r[1] <= sat32(66'(vel_r[1]) + 66'(cmd_r.vy));
              vel_r[2] <= sat32(66'(vel_r[2]) + 66'(cmd_r.vz));
            end
            default: ;
          endcase
        end
        S_INER: sq_r <= sqs[64] ? '1 : sqs[63:0];
        S_INER2: begin
          dn_r <= qv;
          fk_r <= '0;
        end
        S_FIVE: begin
          fk_r <= fk_r + 1'b1;
          case (fk_r)
            3'd0: dq_r <= (dn_r >> 1) + (dn_r >> 2);
            3'd1: dq_r <= dq_r + (dq_r >> 4);
            3'd2: dq_r <= dq_r + (dq_r >> 8);
            3'd3: dq_r <= dq_r + (dq_r >> 16);
            3'd4: dq_r <= dq_r + (dq_r >> 32);
            3'd5: begin
              dq_r <= dq_r >> 2;
              dr_r <= 6'(dn_r - ((dq_r >> 2) << 2) - (dq_r >> 2));
            end
            default: inr_r <= {fq[62:0], 1'b0} + 64'(fr >= 3'd3);
          endcase
        end
        S_DIV: if (zero_den) acc_r <= '0;
        S_DIVW: if (div_done) acc_r <= div_q;
        S_ACC: prod_r <= 66'(acc_r) * $signed({50'd0, cmd_r.dt});
        S_VADD: begin
          prod_r <= 66'(sat32(66'(cur) + 66'(mres))) * DAMP;
        end
        S_DAMP: begin
          if (ang_r) spin_r[ax_r] <= (66'(dres) > -66'(EPS) && 66'(dres) < 66'(EPS))
            ? '0 : dres;
          else vel_r[ax_r] <= (66'(dres) > -66'(EPS) && 66'(dres) < 66'(EPS))
            ? '0 : dres;
        end
        S_POS: begin
          if (ax_r == 2'd2) begin
            ax_r <= '0;
            if (!ang_r && cfg.is_box) begin
              ang_r <= 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                pos_r[i] <= sat32(66'(pos_r[i]) +
                  ((66'(vel_r[i]) * $signed({50'd0, cmd_r.dt})) >>> DT_BITS));
                if (cfg.is_box)
                  ori_r[i] <= sat32(66'(ori_r[i]) +
                    ((66'(spin_r[i]) * $signed({50'd0, cmd_r.dt})) >>> DT_BITS));
              end
            end
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
